/* hdl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared sizes, codes and types of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;

  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int WORD_IW = $clog2(WORD_COUNT);
  localparam int BIT_IW  = $clog2(WORD_BITS);

  // The find-first unit covers both the word summaries and one bitmap word
  localparam int FIND_W  = (WORD_BITS > WORD_COUNT) ? WORD_BITS : WORD_COUNT;
  localparam int FIND_IW = $clog2(FIND_W);

  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(MAX_SLOTS);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

/* hdl/bsa_find_first.sv */
// ----------------------------------------------------------------------------
// bsa_find_first
// Shared priority encoder: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module bsa_find_first (
  input  logic [bsa_pkg::FIND_W-1:0]  vec,
  output logic                        found,
  output logic [bsa_pkg::FIND_IW-1:0] idx
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = bsa_pkg::FIND_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        idx   = bsa_pkg::FIND_IW'(i);
      end
    end
  end

endmodule

/* hdl/bsa_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Bitmap word store, one write and one registered read port; rows that were
// never written since reset read as zero.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bsa_pkg::WORD_IW-1:0] rd_addr,
  output bsa_pkg::word_t              rd_data,
  input  logic                        wr_en,
  input  logic [bsa_pkg::WORD_IW-1:0] wr_addr,
  input  bsa_pkg::word_t              wr_data
);

  bsa_pkg::word_t                    mem [bsa_pkg::WORD_COUNT];
  logic [bsa_pkg::WORD_COUNT-1:0]    row_valid;
  bsa_pkg::word_t                    rd_word;
  logic                              rd_ok;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  // Track written rows
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_ok <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_word : '0;

endmodule

/* hdl/bitmap_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Slot allocator over a bitmap of use marks with per-word full and used
// summaries; one shared find-first unit serves every search step.
// ----------------------------------------------------------------------------
// Channel   Signals                                    Handshake
// request   opcode, slot_index                         start & !busy
// result    granted_index, status, lowest_used,        result_valid strobe,
//           any_used                                   one cycle, no stall
// config    cfg_data (slot_count)                      cfg_valid & cfg_ready
//
// A request holds busy from the accept edge through the result. The next
// request can be taken in the cycle after the result; requests never overlap.
// Steps: word search and read (accept cycle), bit search and update,
// used-word search and read, lowest-bit search; the one find-first unit and
// the registered RAM read set this. The result is shown in the last step.
// Reset frees every slot and sets slot_count to 1024; no clearing pass.
// The receiver cannot stall, and cfg_ready is always high.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [bsa_pkg::SLOT_W-1:0] slot_index,
  output logic                       result_valid,
  output logic [bsa_pkg::SLOT_W-1:0] granted_index,
  output logic [1:0]                 status,
  output logic [bsa_pkg::SLOT_W-1:0] lowest_used,
  output logic                       any_used,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bsa_pkg::CNT_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MODIFY = 5'b00010,
    S_LOWRD  = 5'b00100,
    S_REPORT = 5'b01000,
    S_SPARE  = 5'b10000
  } state_t;

  state_t                          state;
  state_t                          state_next;

  logic [bsa_pkg::CNT_W-1:0]       slot_count;
  logic [bsa_pkg::CNT_W-1:0]       limit;

  logic [bsa_pkg::WORD_COUNT-1:0]  full_vec;
  logic [bsa_pkg::WORD_COUNT-1:0]  used_vec;

  logic                            op_q;
  logic [bsa_pkg::SLOT_W-1:0]      idx_q;
  logic [bsa_pkg::WORD_IW-1:0]     word_q;
  logic                            nofree_q;
  logic [bsa_pkg::SLOT_W-1:0]      granted_q;
  bsa_pkg::status_t                status_q;
  logic                            any_q;

  logic [bsa_pkg::FIND_W-1:0]      find_vec;
  logic                            find_found;
  logic [bsa_pkg::FIND_IW-1:0]     find_idx;

  logic [bsa_pkg::WORD_IW-1:0]     rd_addr;
  bsa_pkg::word_t                  rd_data;
  logic                            wr_en;
  bsa_pkg::word_t                  wr_data;

  logic [bsa_pkg::SLOT_W-1:0]      cand_slot;
  bsa_pkg::word_t                  onehot;
  bsa_pkg::status_t                mod_status;
  logic [bsa_pkg::SLOT_W-1:0]      mod_granted;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= bsa_pkg::SLOT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_count <= cfg_data;
    end
  end

  // Clamp the slot count to the bitmap size
  assign limit = (slot_count > bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS)) ?
                 bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS) : slot_count;

  // Feed the shared find-first unit for the current step
  always_comb begin
    unique case (state)
      S_IDLE:   find_vec = bsa_pkg::FIND_W'(~full_vec);
      S_MODIFY: find_vec = bsa_pkg::FIND_W'(~rd_data);
      S_LOWRD:  find_vec = bsa_pkg::FIND_W'(used_vec);
      S_REPORT: find_vec = bsa_pkg::FIND_W'(rd_data);
      default:  find_vec = '0;
    endcase
  end

  bsa_find_first u_find (
    .vec   (find_vec),
    .found (find_found),
    .idx   (find_idx)
  );

  // Pick the word to read
  always_comb begin
    unique case (state)
      S_IDLE: begin
        rd_addr = (opcode == bsa_pkg::OP_RELEASE) ?
                  slot_index[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IW] :
                  find_idx[bsa_pkg::WORD_IW-1:0];
      end
      S_LOWRD: rd_addr = find_idx[bsa_pkg::WORD_IW-1:0];
      default: rd_addr = word_q;
    endcase
  end

  bsa_bitmap_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_q),
    .wr_data (wr_data)
  );

  // Decide the update of the fetched word
  assign cand_slot = {word_q, find_idx[bsa_pkg::BIT_IW-1:0]};

  always_comb begin
    onehot      = '0;
    wr_en       = 1'b0;
    wr_data     = rd_data;
    mod_status  = bsa_pkg::ST_OK;
    mod_granted = '0;
    if (op_q == bsa_pkg::OP_ALLOC) begin
      onehot = bsa_pkg::word_t'(1) << find_idx[bsa_pkg::BIT_IW-1:0];
      priority if (nofree_q || ({1'b0, cand_slot} >= limit)) begin
        mod_status = bsa_pkg::ST_FULL;
      end else begin
        wr_en       = (state == S_MODIFY);
        wr_data     = rd_data | onehot;
        mod_granted = cand_slot;
      end
    end else begin
      onehot = bsa_pkg::word_t'(1) << idx_q[bsa_pkg::BIT_IW-1:0];
      priority if ({1'b0, idx_q} >= limit) begin
        mod_status = bsa_pkg::ST_RANGE;
      end else if (!rd_data[idx_q[bsa_pkg::BIT_IW-1:0]]) begin
        mod_status = bsa_pkg::ST_FREE;
      end else begin
        wr_en   = (state == S_MODIFY);
        wr_data = rd_data & ~onehot;
      end
    end
  end

  // Advance the sequencer
  always_comb begin
    unique case (state)
      S_IDLE:   state_next = start ? S_MODIFY : S_IDLE;
      S_MODIFY: state_next = S_LOWRD;
      S_LOWRD:  state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      full_vec <= '0;
      used_vec <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        full_vec[word_q] <= &wr_data;
        used_vec[word_q] <= |wr_data;
      end
    end
  end

  // Hold the request and the partial result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_q     <= opcode;
        idx_q    <= slot_index;
        word_q   <= rd_addr;
        nofree_q <= !find_found;
      end
      S_MODIFY: begin
        status_q  <= mod_status;
        granted_q <= mod_granted;
      end
      S_LOWRD: begin
        any_q  <= find_found;
        word_q <= rd_addr;
      end
      default: begin
      end
    endcase
  end

  // Drive the result strobe and fields
  assign busy          = (state != S_IDLE);
  assign result_valid  = (state == S_REPORT);
  assign granted_index = granted_q;
  assign status        = status_q;
  assign any_used      = any_q;
  assign lowest_used   = any_q ? {word_q, find_idx[bsa_pkg::BIT_IW-1:0]} : '0;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_full_implies_used: assert property (@(posedge clk) disable iff (rst)
    ((full_vec & ~used_vec) == '0))
    else $error("word marked full but not used");

  a_alloc_ok_used: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (op_q == bsa_pkg::OP_ALLOC) && (status == bsa_pkg::ST_OK))
      |-> (any_used && (lowest_used <= granted_index)))
    else $error("granted slot not reflected in lowest used slot");
`endif

endmodule
